// ----- hw/rtl/dle_pkg.sv -----
// ----------------------------------------------------------------------------
// dle_pkg - shared definitions for the DLE stuffed frame deframer
// Framing symbols, result kinds, queue entry type and default sizes.
// ----------------------------------------------------------------------------
package dle_pkg;

   localparam int DLE_FRAME_BUFFER_BYTES = 4096;
   localparam int DLE_QUEUE_DEPTH        = 4;

   localparam logic [11:0] DLE_MAX_PAYLOAD_RESET = 12'd4095;
   localparam logic [11:0] DLE_LENGTH_CEILING    = 12'd4095;

   localparam logic [7:0] SYM_SOH = 8'h01;
   localparam logic [7:0] SYM_DLE = 8'h10;
   localparam logic [7:0] SYM_ETB = 8'h17;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_LONG  = 2'd2,
      KIND_ABORT = 2'd3
   } kind_type;

   // One classified received byte, as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_soh;
      logic       is_dle;
      logic       is_etb;
   } beat_type;

endpackage

// ----- hw/rtl/dle_stuffed_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// dle_stuffed_frame_deframer_unit - SOH/ETB framed, DLE stuffed byte deframer
// Streams unescaped payload bytes and closes each frame with a verdict.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  req_      in         req_valid/ready    rx_byte
//  rsp_      out        rsp_valid/ready    kind, data_byte, control_byte,
//                                          payload_length
//  csr_      in         csr_wr_en          max_payload (12 bits)
//
// One byte is accepted per cycle while the queue has room; a byte passes
// through the queue slot register and then the result register.
// A four-beat queue lets the input keep flowing while a result waits.
// Synchronous reset returns to waiting for SOH with max_payload at 4095.
// When the queue is full, req_ready drops until the result side moves.
// ----------------------------------------------------------------------------
module dle_stuffed_frame_deframer_unit import dle_pkg::*; #(
   parameter int FRAME_BUFFER_BYTES = DLE_FRAME_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_control_byte,
   output logic [11:0] rsp_payload_length,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   logic [11:0] max_payload_reg_ff, max_payload_reg_in;
   logic        queue_full;
   logic        push;
   beat_type    push_beat;
   logic        pop;
   logic        head_valid;
   beat_type    head_beat;

   assign max_payload_reg_in = csr_wr_en ? csr_wr_data : max_payload_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_reg_ff <= DLE_MAX_PAYLOAD_RESET;
      end else begin
         max_payload_reg_ff <= max_payload_reg_in;
      end
   end

   dle_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_beat   (push_beat)
   );

   dle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_beat  (push_beat),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_beat  (head_beat)
   );

   dle_back #(
      .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .max_payload        (max_payload_reg_ff),
      .head_valid         (head_valid),
      .head_beat          (head_beat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_control_byte   (rsp_control_byte),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

// ----- hw/rtl/dle_front.sv -----
// ----------------------------------------------------------------------------
// dle_front - input acceptance and byte classification
// Takes received bytes and tags them with their framing symbol class.
// ----------------------------------------------------------------------------
module dle_front import dle_pkg::*; (
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       queue_full,
   output logic       push,
   output beat_type   push_beat
);

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_beat.rx_byte = req_rx_byte;
      push_beat.is_soh  = (req_rx_byte == SYM_SOH);
      push_beat.is_dle  = (req_rx_byte == SYM_DLE);
      push_beat.is_etb  = (req_rx_byte == SYM_ETB);
   end

endmodule

// ----- hw/rtl/dle_queue.sv -----
// ----------------------------------------------------------------------------
// dle_queue - short beat queue between front and back
// Register based first-in first-out buffer of classified bytes.
// ----------------------------------------------------------------------------
module dle_queue import dle_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  beat_type push_beat,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output beat_type head_beat
);

   localparam int PW = $clog2(DLE_QUEUE_DEPTH);
   localparam int CW = $clog2(DLE_QUEUE_DEPTH + 1);

   beat_type        slot_ff [DLE_QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;

   assign full       = (fill_ff == CW'(DLE_QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_beat  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DLE_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DLE_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

// ----- hw/rtl/dle_back.sv -----
// ----------------------------------------------------------------------------
// dle_back - frame state tracking and result generation
// Walks the frame state for each queued beat and registers the results.
// ----------------------------------------------------------------------------
module dle_back import dle_pkg::*; #(
   parameter int FRAME_BUFFER_BYTES = DLE_FRAME_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] max_payload,
   input  logic        head_valid,
   input  beat_type    head_beat,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_control_byte,
   output logic [11:0] rsp_payload_length
);

   localparam int CW = $clog2(FRAME_BUFFER_BYTES + 1);
   localparam int LW = (CW > 12) ? CW : 12;

   logic          in_frame_ff, in_frame_in;
   logic          escape_ff, escape_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    control_ff, control_in;

   logic          out_valid_ff, out_valid_in;
   kind_type      kind_ff, kind_in;
   logic [7:0]    data_ff, data_in;
   logic [7:0]    out_control_ff, out_control_in;
   logic [11:0]   length_ff, length_in;

   logic          emit;
   logic          has_room;
   logic [LW-1:0] length_wide;

   assign pop      = head_valid && (!out_valid_ff || rsp_ready);
   assign has_room = (count_ff < CW'(FRAME_BUFFER_BYTES));
   // The length excludes the control byte, which is counted too.
   assign length_wide = LW'(count_ff) - LW'(1);

   always_comb begin
      in_frame_in    = in_frame_ff;
      escape_in      = escape_ff;
      count_in       = count_ff;
      control_in     = control_ff;
      emit           = 1'b0;
      kind_in        = kind_ff;
      data_in        = data_ff;
      out_control_in = out_control_ff;
      length_in      = length_ff;

      if (pop) begin
         if (!in_frame_ff) begin
            if (head_beat.is_soh) begin
               in_frame_in = 1'b1;
               escape_in   = 1'b0;
               count_in    = '0;
            end
         end else if (count_ff == '0) begin
            // The byte right after SOH is taken raw, whatever its value.
            control_in = head_beat.rx_byte;
            count_in   = CW'(1);
         end else if (escape_ff) begin
            escape_in = 1'b0;
            if (has_room) begin
               count_in  = count_ff + 1'b1;
               emit      = 1'b1;
               kind_in   = KIND_DATA;
               data_in   = head_beat.rx_byte;
               length_in = '0;
            end
         end else if (head_beat.is_dle) begin
            escape_in = 1'b1;
         end else if (head_beat.is_etb) begin
            in_frame_in = 1'b0;
            count_in    = '0;
            emit        = 1'b1;
            kind_in     = (length_wide > LW'(max_payload)) ? KIND_LONG : KIND_END;
            data_in     = '0;
            length_in   = (length_wide > LW'(DLE_LENGTH_CEILING)) ? DLE_LENGTH_CEILING
                                                                  : length_wide[11:0];
         end else if (has_room) begin
            count_in  = count_ff + 1'b1;
            emit      = 1'b1;
            kind_in   = KIND_DATA;
            data_in   = head_beat.rx_byte;
            length_in = '0;
         end else begin
            in_frame_in = 1'b0;
            count_in    = '0;
            emit        = 1'b1;
            kind_in     = KIND_ABORT;
            data_in     = '0;
            length_in   = '0;
         end
         out_control_in = control_ff;
      end

      if (pop) begin
         out_valid_in = emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         escape_ff    <= 1'b0;
         count_ff     <= '0;
         control_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         escape_ff    <= escape_in;
         count_ff     <= count_in;
         control_ff   <= control_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff        <= kind_in;
         data_ff        <= data_in;
         out_control_ff <= out_control_in;
         length_ff      <= length_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_control_byte   = out_control_ff;
   assign rsp_payload_length = length_ff;

endmodule

// ----- hw/rtl/dle_checker.sv -----
// ----------------------------------------------------------------------------
// dle_checker - port level checks for the deframer
// Watches the result channel for hold and field consistency.
// ----------------------------------------------------------------------------
module dle_checker import dle_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [7:0]  rsp_control_byte,
   input logic [11:0] rsp_payload_length
);

   // A result beat that is not taken must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_control_byte)
         && $stable(rsp_payload_length))
      else $error("result beat changed while stalled");

   // Payload byte beats never carry a length.
   a_data_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DATA) |-> rsp_payload_length == '0)
      else $error("payload byte beat with nonzero length");

   // Verdict beats never carry a data byte.
   a_verdict_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_DATA) |-> rsp_data_byte == '0)
      else $error("verdict beat with nonzero data byte");

   // An abort reports no length.
   a_abort_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ABORT) |-> rsp_payload_length == '0)
      else $error("abort beat with nonzero length");

endmodule

bind dle_stuffed_frame_deframer_unit dle_checker u_dle_checker (.*);

// ----- tb/sv/tb_dle_stuffed_frame_deframer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dle_stuffed_frame_deframer_unit - self-checking bench for the deframer
// Feeds SOH/ETB framed, DLE stuffed byte streams with random gaps on both
// channels, predicts every result beat in step with the input, and compares
// each beat field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_dle_stuffed_frame_deframer_unit;
   import dle_pkg::*;

   localparam int          BUFFER_BYTES  = DLE_FRAME_BUFFER_BYTES;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          CYCLE_LIMIT   = 2000000;
   localparam int unsigned RANDOM_ITEMS  = 1650;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  control_byte;
      logic [11:0] payload_length;
   } deframed_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_control_byte;
   logic [11:0] rsp_payload_length;
   logic        csr_wr_en = 1'b0;
   logic [11:0] csr_wr_data = 12'h000;

   // Predicted deframer state.
   bit          frame_open = 1'b0;
   bit          dle_seen = 1'b0;
   int unsigned stored_bytes = 0;
   logic [7:0]  ctrl_latched = 8'h00;
   logic [11:0] payload_limit = DLE_MAX_PAYLOAD_RESET;

   deframed_beat_type beats_due[$];
   deframed_beat_type due_beat;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int unsigned       framed_items = 0;
   int unsigned       sink_hold = 0;
   bit                idle_off = 1'b0;

   dle_stuffed_frame_deframer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_control_byte   (rsp_control_byte),
      .rsp_payload_length (rsp_payload_length),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      if (idle_off) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advances the predicted state by one received byte. Returns 1 when the byte
   // produces a result beat.
   function automatic bit deframe_byte(input logic [7:0] rx, output deframed_beat_type beat);
      int unsigned len;
      beat.kind           = KIND_DATA;
      beat.data_byte      = 8'h00;
      beat.control_byte   = ctrl_latched;
      beat.payload_length = 12'h000;
      if (!frame_open) begin
         if (rx == SYM_SOH) begin
            frame_open   = 1'b1;
            dle_seen     = 1'b0;
            stored_bytes = 0;
         end
         return 1'b0;
      end
      if (stored_bytes == 0) begin
         ctrl_latched = rx;
         stored_bytes = 1;
         return 1'b0;
      end
      if (dle_seen) begin
         dle_seen = 1'b0;
         // An escaped byte that finds the buffer full is simply lost.
         if (stored_bytes >= BUFFER_BYTES) return 1'b0;
         stored_bytes++;
         beat.data_byte = rx;
         return 1'b1;
      end
      if (rx == SYM_DLE) begin
         dle_seen = 1'b1;
         return 1'b0;
      end
      if (rx == SYM_ETB) begin
         len = stored_bytes - 1;
         beat.kind = (len > payload_limit) ? KIND_LONG : KIND_END;
         beat.payload_length = (len > DLE_LENGTH_CEILING) ? DLE_LENGTH_CEILING : len[11:0];
         frame_open   = 1'b0;
         stored_bytes = 0;
         return 1'b1;
      end
      if (stored_bytes < BUFFER_BYTES) begin
         stored_bytes++;
         beat.data_byte = rx;
         return 1'b1;
      end
      frame_open   = 1'b0;
      stored_bytes = 0;
      beat.kind    = KIND_ABORT;
      return 1'b1;
   endfunction

   task automatic compare_field(input string field, input logic [11:0] want,
                                input logic [11:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (beats_due.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got kind %0d data 0x%0h",
                     $time, rsp_kind, rsp_data_byte);
            mismatch_count++;
         end else begin
            due_beat = beats_due.pop_front();
            compare_field("kind", 12'(due_beat.kind), 12'(rsp_kind));
            compare_field("data_byte", 12'(due_beat.data_byte), 12'(rsp_data_byte));
            compare_field("control_byte", 12'(due_beat.control_byte),
                          12'(rsp_control_byte));
            compare_field("payload_length", due_beat.payload_length, rsp_payload_length);
         end
      end
   end

   // Result side: random stalls, or a long hold-off counted here on request.
   initial begin : sink_side
      int unsigned gap;
      @(posedge clock);
      forever begin
         if (sink_hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold) @(posedge clock);
            sink_hold = 0;
         end else begin
            gap = idle_cycles();
            if (gap == 0) begin
               rsp_ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] rx);
      int unsigned       gap;
      deframed_beat_type beat;
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (frame_open || rx == SYM_SOH) framed_items++;
      if (deframe_byte(rx, beat)) beats_due.push_back(beat);
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sends one payload byte, stuffing it when it is DLE or ETB or when asked to.
   task automatic send_payload(input logic [7:0] rx, input bit escape_anyway);
      if (rx == SYM_DLE || rx == SYM_ETB || escape_anyway) send_byte(SYM_DLE);
      send_byte(rx);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_payload(input logic [11:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      payload_limit = value;
      @(posedge clock);
   endtask

   task automatic test_directed_frames();
      // Noise outside a frame, framing symbols among it.
      send_byte(SYM_ETB);
      send_byte(SYM_DLE);
      send_byte(8'hFF);
      send_byte(8'h00);
      // SOH as the control byte, SOH inside the payload, escaped ETB and DLE.
      send_byte(SYM_SOH);
      send_byte(SYM_SOH);
      send_byte(SYM_SOH);
      send_payload(SYM_ETB, 1'b0);
      send_payload(SYM_DLE, 1'b0);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(SYM_ETB);
      // DLE and ETB taken raw as control bytes; the first frame has an empty payload.
      send_byte(SYM_SOH);
      send_byte(SYM_DLE);
      send_byte(SYM_ETB);
      send_byte(SYM_SOH);
      send_byte(SYM_ETB);
      send_byte(8'hAA);
      send_byte(SYM_ETB);
      wait_drained();
      write_max_payload(12'd0);
      send_byte(SYM_SOH);
      send_byte(8'h55);
      send_byte(8'h66);
      send_byte(SYM_ETB);
      wait_drained();
   endtask

   task automatic test_backpressure();
      write_max_payload(DLE_MAX_PAYLOAD_RESET);
      // The sink holds off while the source streams without gaps, so the
      // block has to fill up and push back on its input.
      sink_hold = 80;
      idle_off  = 1'b1;
      send_byte(SYM_SOH);
      send_byte(8'h3C);
      repeat (40) send_payload(8'($urandom_range(0, 255)), 1'b0);
      send_byte(SYM_ETB);
      idle_off = 1'b0;
      wait_drained();
   endtask

   task automatic send_random_frame(input int unsigned longest);
      int unsigned count;
      logic [7:0]  rx;
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      send_byte(SYM_SOH);
      send_byte(8'($urandom_range(0, 255)));
      count = $urandom_range(0, longest);
      repeat (count) begin
         rx = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 19))
            0: rx = SYM_SOH;
            1: rx = SYM_DLE;
            2: rx = SYM_ETB;
            default: ;
         endcase
         send_payload(rx, $urandom_range(0, 9) == 0);
      end
      case ($urandom_range(0, 19))
         // Frame left open: the next SOH lands in its payload.
         0: ;
         // Stray DLE swallows the ETB, which then becomes payload.
         1: begin
            send_byte(SYM_DLE);
            send_byte(SYM_ETB);
         end
         default: send_byte(SYM_ETB);
      endcase
   endtask

   task automatic test_random_traffic();
      logic [11:0] limit;
      int unsigned phase;
      int unsigned stop_at;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: limit = 12'd4095;
            1: limit = 12'd0;
            2: limit = 12'($urandom_range(0, 24));
            3: limit = 12'($urandom_range(0, 4095));
            default: limit = 12'($urandom_range(1, 16));
         endcase
         write_max_payload(limit);
         stop_at = framed_items + RANDOM_ITEMS / 5;
         while (framed_items < stop_at) begin
            idle_off = (phase == 4) || ($urandom_range(0, 11) == 0);
            send_random_frame(($urandom_range(0, 9) == 0) ? 48 : 20);
         end
         idle_off = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0 && beats_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
